// ===== hdl/ookpwm_pkg.sv =====
`timescale 1ns / 1ps

package ookpwm_pkg;

  localparam int DUR_W   = 16;
  localparam int SYNC_W  = 9;
  localparam int BITS_W  = 7;
  localparam int FRAME_W = 80;
  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_GAP      = 3'd0,
    REG_BIT1_MIN      = 3'd1,
    REG_STOP_GAP      = 3'd2,
    REG_SYNC_EARLIEST = 3'd3,
    REG_MIN_BITS      = 3'd4
  } cfg_reg_t;

  localparam logic [DUR_W-1:0]  SYNC_GAP_RST      = 16'd40;
  localparam logic [DUR_W-1:0]  BIT1_MIN_RST      = 16'd8;
  localparam logic [DUR_W-1:0]  STOP_GAP_RST      = 16'd30;
  localparam logic [SYNC_W-1:0] SYNC_EARLIEST_RST = 9'd6;
  localparam logic [BITS_W-1:0] MIN_BITS_RST      = 7'd32;

  typedef struct packed {
    logic [DUR_W-1:0]  sync_gap_min;
    logic [DUR_W-1:0]  bit1_min;
    logic [DUR_W-1:0]  stop_gap_min;
    logic [SYNC_W-1:0] sync_earliest;
    logic [BITS_W-1:0] min_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic              bit_valid;
    logic              bit_value;
    logic [BITS_W-1:0] bit_position;
    logic              done_res;
    logic [BITS_W-1:0] total_bits;
    logic              decoded_ok;
    logic [LOW_W-1:0]  frame_low;
    logic [HIGH_W-1:0] frame_high;
  } result_t;

endpackage

// ===== hdl/ookpwm_in_if.sv =====
`timescale 1ns / 1ps

interface ookpwm_in_if
  import ookpwm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;
  logic             last;

  modport source (output valid, duration, last, input ready);
  modport sink   (input valid, duration, last, output ready);
endinterface

// ===== hdl/ookpwm_out_if.sv =====
`timescale 1ns / 1ps

interface ookpwm_out_if
  import ookpwm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              bit_valid;
  logic              bit_value;
  logic [BITS_W-1:0] bit_position;
  logic              done_res;
  logic [BITS_W-1:0] total_bits;
  logic              decoded_ok;
  logic [LOW_W-1:0]  frame_low;
  logic [HIGH_W-1:0] frame_high;

  modport source (
    output valid, bit_valid, bit_value, bit_position, done_res, total_bits,
           decoded_ok, frame_low, frame_high,
    input  ready
  );
  modport sink (
    input  valid, bit_valid, bit_value, bit_position, done_res, total_bits,
           decoded_ok, frame_low, frame_high,
    output ready
  );
endinterface

// ===== hdl/ookpwm_cfg_regs.sv =====
`timescale 1ns / 1ps

module ookpwm_cfg_regs
  import ookpwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_GAP:      cfg_nxt.sync_gap_min  = cfg_wdata;
        REG_BIT1_MIN:      cfg_nxt.bit1_min      = cfg_wdata;
        REG_STOP_GAP:      cfg_nxt.stop_gap_min  = cfg_wdata;
        REG_SYNC_EARLIEST: cfg_nxt.sync_earliest = cfg_wdata[SYNC_W-1:0];
        REG_MIN_BITS:      cfg_nxt.min_bits      = cfg_wdata[BITS_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_gap_min  <= SYNC_GAP_RST;
      cfg_r.bit1_min      <= BIT1_MIN_RST;
      cfg_r.stop_gap_min  <= STOP_GAP_RST;
      cfg_r.sync_earliest <= SYNC_EARLIEST_RST;
      cfg_r.min_bits      <= MIN_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/ookpwm_in_stage.sv =====
`timescale 1ns / 1ps

module ookpwm_in_stage
  import ookpwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ookpwm_in_if.sink in_if,
  input  logic     s1_take,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // Stage empties or drains this cycle -> room for a new transfer
  assign in_if.ready = !valid_r || s1_take;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.duration <= in_if.duration;
      item_r.last     <= in_if.last;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hdl/ookpwm_decode.sv =====
`timescale 1ns / 1ps

module ookpwm_decode
  import ookpwm_pkg::*;
#(
  parameter int EDGE_LIMIT = 512,
  parameter int BIT_LIMIT  = 80
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     s1_valid,
  input  in_item_t s1_item,
  output logic     s1_take,
  ookpwm_out_if.source out_if
);

  localparam int EW = $clog2(EDGE_LIMIT + 1);
  localparam int CW = (EW > SYNC_W) ? EW : SYNC_W;
  localparam logic [EW-1:0]     EDGE_LIM = EW'(EDGE_LIMIT);
  localparam logic [BITS_W-1:0] BIT_LIM  = BITS_W'(BIT_LIMIT);

  logic [EW-1:0]      edge_r, edge_nxt;
  phase_t             phase_r, phase_nxt;
  logic [BITS_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;

  assign s1_take = s1_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    edge_nxt  = edge_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    res_nxt   = '0;

    if (edge_r < EDGE_LIM) begin
      edge_nxt = edge_r + 1'b1;
      if (edge_r[0]) begin  // low level
        unique case (phase_r)
          PH_HUNT: begin
            if (s1_item.duration >= cfg.sync_gap_min &&
                CW'(edge_r) >= CW'(cfg.sync_earliest)) begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (s1_item.duration >= cfg.stop_gap_min) begin
              phase_nxt = PH_DONE;
            end else if (cnt_r < BIT_LIM) begin
              res_nxt.bit_valid    = 1'b1;
              res_nxt.bit_value    = (s1_item.duration >= cfg.bit1_min);
              res_nxt.bit_position = cnt_r;
              if (res_nxt.bit_value) begin
                frame_nxt[cnt_r] = 1'b1;
              end
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_nxt >= BIT_LIM) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end

    // Summary includes this item's bit, then the capture starts over
    if (s1_item.last) begin
      res_nxt.done_res   = 1'b1;
      res_nxt.total_bits = cnt_nxt;
      res_nxt.decoded_ok = (phase_nxt != PH_HUNT) && (cnt_nxt >= cfg.min_bits);
      res_nxt.frame_low  = frame_nxt[LOW_W-1:0];
      res_nxt.frame_high = frame_nxt[FRAME_W-1:LOW_W];
      edge_nxt  = '0;
      phase_nxt = PH_HUNT;
      cnt_nxt   = '0;
      frame_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r      <= '0;
      phase_r     <= PH_HUNT;
      cnt_r       <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        edge_r  <= edge_nxt;
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        frame_r <= frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.bit_valid    = res_r.bit_valid;
  assign out_if.bit_value    = res_r.bit_value;
  assign out_if.bit_position = res_r.bit_position;
  assign out_if.done_res     = res_r.done_res;
  assign out_if.total_bits   = res_r.total_bits;
  assign out_if.decoded_ok   = res_r.decoded_ok;
  assign out_if.frame_low    = res_r.frame_low;
  assign out_if.frame_high   = res_r.frame_high;

endmodule

// ===== hdl/ook_pwm_pulse_decoder_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake           Payload
// in_if    in   valid/ready         duration[15:0], last
// out_if   out  valid/ready         bit_valid, bit_value, bit_position[6:0], done_res,
//                                   total_bits[6:0], decoded_ok, frame_low[63:0],
//                                   frame_high[15:0]
// cfg_*    in   cfg_we (no ready)   cfg_index[2:0], cfg_wdata[15:0]
//
// One item per cycle while out_if.ready holds; an item passes the input register, then the result register.
// The per-edge decode is a few 16-bit compares between those two registers.
// Reset (rst_n low, synchronous) restores default registers and clears the capture.
// A stalled result holds in the result register; the input register still takes one
// more transfer, then in_if.ready drops until out_if.ready returns.

module ook_pwm_pulse_decoder_unit
  import ookpwm_pkg::*;
#(
  parameter int EDGE_LIMIT = 512,  // edges at or past this index are ignored
  parameter int BIT_LIMIT  = 80    // bits per frame, at most 80
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ookpwm_in_if.sink             in_if,
  ookpwm_out_if.source          out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  logic     s1_valid;
  logic     s1_take;
  in_item_t s1_item;

  // Threshold registers; the user must write them only while the pipe is idle, the block does not enforce it
  ookpwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register; a full one reopens in the same cycle the result side takes its item
  ookpwm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Sync hunt, bit decode, frame packing and the result register
  ookpwm_decode #(
    .EDGE_LIMIT (EDGE_LIMIT),
    .BIT_LIMIT  (BIT_LIMIT)
  ) u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .out_if   (out_if)
  );

endmodule

// ===== bench/tb_ook_pwm_pulse_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_ook_pwm_pulse_decoder_unit;
  import ookpwm_pkg::*;

  localparam int EDGE_LIMIT   = 512;
  localparam int BIT_LIMIT    = 80;
  localparam int RANDOM_EDGES = 280;     // random part stops once this many edges are queued
  localparam int CYCLE_LIMIT  = 600000;  // watchdog, far above the slowest legal run
  localparam int MAX_DUR      = 65535;

  // Shape of the end of a generated capture
  typedef enum int {
    TAIL_LAST_ON_BIT,  // last mark sits on the final data low
    TAIL_END_GAP,      // frame closed by a long low, then a few stray edges
    TAIL_NO_SYNC       // sync slot carries a short low, so the hunt does not end there
  } tail_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ookpwm_in_if  in_if ();
  ookpwm_out_if out_if ();

  ook_pwm_pulse_decoder_unit #(
    .EDGE_LIMIT(EDGE_LIMIT),
    .BIT_LIMIT (BIT_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Stimulus and expectations
  in_item_t edge_queue[$];       // edges waiting for the driver
  in_item_t capture_buf[$];      // capture under construction
  result_t  pending_decodes[$];  // predicted results, oldest first
  int       edges_queued = 0;
  int       mismatches   = 0;
  int       cycle_count  = 0;
  int       calm_left    = 0;    // >0: neither side idles

  // Shadow of the register file and of the capture state
  cfg_t         shadow_cfg;
  logic [9:0]   edge_pos;
  phase_t       phase;
  logic [6:0]   bit_cnt;
  logic [63:0]  frame_lo;
  logic [15:0]  frame_hi;
  logic         synced;

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  // Duration of at least lo, usually close to it
  function automatic int unsigned at_least(int unsigned lo);
    if ($urandom_range(3) == 0) return pick(lo, MAX_DUR);
    return pick(lo, (lo + 100 > MAX_DUR) ? MAX_DUR : lo + 100);
  endfunction

  // Mostly zero, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void restart_capture();
    edge_pos = '0;
    phase    = PH_HUNT;
    bit_cnt  = '0;
    frame_lo = '0;
    frame_hi = '0;
    synced   = 1'b0;
  endfunction

  // Decoder prediction for one edge; updates the shadow capture state.
  function automatic result_t decode_edge(logic [DUR_W-1:0] dur, logic last);
    result_t    res;
    logic [9:0] pos;
    res = '0;
    if (edge_pos < EDGE_LIMIT) begin
      pos      = edge_pos;
      edge_pos = edge_pos + 10'd1;
      if (pos[0]) begin
        // low level: sync hunt or data bit
        if (phase == PH_HUNT) begin
          if (dur >= shadow_cfg.sync_gap_min && pos >= shadow_cfg.sync_earliest) begin
            phase  = PH_DATA;
            synced = 1'b1;
          end
        end else if (phase == PH_DATA) begin
          if (dur >= shadow_cfg.stop_gap_min) begin
            phase = PH_DONE;
          end else if (bit_cnt < BIT_LIMIT) begin
            res.bit_valid    = 1'b1;
            res.bit_value    = (dur >= shadow_cfg.bit1_min);
            res.bit_position = bit_cnt;
            if (res.bit_value) begin
              if (bit_cnt < 64) frame_lo[bit_cnt] = 1'b1;
              else frame_hi[bit_cnt - 7'd64] = 1'b1;
            end
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= BIT_LIMIT) phase = PH_DONE;
          end else begin
            phase = PH_DONE;
          end
        end
      end
    end
    // summary includes a bit decoded on this very edge
    if (last) begin
      res.done_res   = 1'b1;
      res.total_bits = bit_cnt;
      res.decoded_ok = synced && (bit_cnt >= shadow_cfg.min_bits);
      res.frame_low  = frame_lo;
      res.frame_high = frame_hi;
      restart_capture();
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Capture construction
  // ---------------------------------------------------------------------------
  task automatic stage(int unsigned dur);
    in_item_t it;
    it.duration = dur[DUR_W-1:0];
    it.last     = 1'b0;
    capture_buf.push_back(it);
  endtask

  // Marks the final staged edge as last and hands the capture to the driver
  task automatic flush_capture();
    capture_buf[capture_buf.size()-1].last = 1'b1;
    foreach (capture_buf[k]) edge_queue.push_back(capture_buf[k]);
    edges_queued += capture_buf.size();
    capture_buf.delete();
  endtask

  function automatic int unsigned high_dur();
    if ($urandom_range(9) == 0) return $urandom_range(MAX_DUR, 1);
    return $urandom_range(12, 1);
  endfunction

  // Data low: mostly a clean 0 or 1, sometimes anything at all
  function automatic int unsigned data_low();
    int r;
    r = $urandom_range(19);
    if (r == 0) return $urandom_range(MAX_DUR, 1);
    if (r < 10) return pick(1, shadow_cfg.bit1_min - 1);
    return pick(shadow_cfg.bit1_min, shadow_cfg.stop_gap_min - 1);
  endfunction

  // Preamble, sync gap, nbits data pulses, then the chosen tail
  task automatic add_capture(int nbits, tail_kind_t tail);
    int unsigned sync_at;
    int unsigned pos;
    int          extra;
    sync_at = shadow_cfg.sync_earliest | 1;
    if (sync_at + 6 < EDGE_LIMIT) sync_at += 2 * $urandom_range(3);
    for (pos = 0; pos < sync_at; pos++) begin
      if (!pos[0]) stage(high_dur());
      else if (pos >= shadow_cfg.sync_earliest) stage(pick(1, shadow_cfg.sync_gap_min - 1));
      // before the earliest sync index even a huge low must not sync
      else if ($urandom_range(1)) stage($urandom_range(MAX_DUR, 1));
      else stage(pick(1, 60));
    end
    if (tail == TAIL_NO_SYNC) stage(pick(1, shadow_cfg.sync_gap_min - 1));
    else stage(at_least(shadow_cfg.sync_gap_min));
    for (int b = 0; b < nbits; b++) begin
      stage(high_dur());
      stage(data_low());
    end
    if (tail != TAIL_LAST_ON_BIT) begin
      stage(high_dur());
      if (tail == TAIL_END_GAP) stage(at_least(shadow_cfg.stop_gap_min));
      else stage(data_low());
      extra = $urandom_range(4);
      repeat (extra) begin
        stage(high_dur());
        stage(data_low());
      end
    end
    flush_capture();
  endtask

  // Unstructured edges
  task automatic add_noise(int len);
    repeat (len) begin
      if ($urandom_range(1)) stage($urandom_range(MAX_DUR, 1));
      else stage($urandom_range(80, 1));
    end
    flush_capture();
  endtask

  task automatic add_random_capture();
    int r;
    int nbits;
    r     = $urandom_range(99);
    nbits = ($urandom_range(4) == 0) ? $urandom_range(90, 60) : $urandom_range(40);
    if (r < 40) add_capture(nbits, TAIL_LAST_ON_BIT);
    else if (r < 72) add_capture(nbits, TAIL_END_GAP);
    else if (r < 86) add_capture($urandom_range(10), TAIL_NO_SYNC);
    else add_noise($urandom_range(30, 1));
  endtask

  // ---------------------------------------------------------------------------
  // Register writes (only while the decoder is idle)
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SYNC_GAP:      shadow_cfg.sync_gap_min  = val;
      REG_BIT1_MIN:      shadow_cfg.bit1_min      = val;
      REG_STOP_GAP:      shadow_cfg.stop_gap_min  = val;
      REG_SYNC_EARLIEST: shadow_cfg.sync_earliest = val[SYNC_W-1:0];
      REG_MIN_BITS:      shadow_cfg.min_bits      = val[BITS_W-1:0];
      default: ;  // unmapped index, write must be dropped
    endcase
  endtask

  task automatic apply_cfg(int unsigned s_min, int unsigned b1_min, int unsigned f_end,
                           int unsigned earliest, int unsigned m_bits);
    write_reg(REG_SYNC_GAP, s_min[CFG_DATA_W-1:0]);
    write_reg(REG_BIT1_MIN, b1_min[CFG_DATA_W-1:0]);
    write_reg(REG_STOP_GAP, f_end[CFG_DATA_W-1:0]);
    write_reg(REG_SYNC_EARLIEST, earliest[CFG_DATA_W-1:0]);
    write_reg(REG_MIN_BITS, m_bits[CFG_DATA_W-1:0]);
    // junk into the unmapped indexes must not disturb anything
    for (int k = int'(REG_MIN_BITS) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(MAX_DUR)));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_cfg();
    int unsigned b1;
    int unsigned m;
    int          r;
    b1 = pick(1, 60);
    r  = $urandom_range(9);
    if (r < 2) m = 0;
    else if (r < 3) m = BIT_LIMIT;
    else if (r < 4) m = $urandom_range(127, BIT_LIMIT + 1);  // never reachable
    else m = $urandom_range(40);
    apply_cfg(pick(10, 300), b1,
              ($urandom_range(7) == 0) ? pick(1, b1) : pick(b1 + 1, b1 + 200),
              $urandom_range(24), m);
  endtask

  // Sampled at the falling edge so that all rising-edge activity has settled.
  // An item passes the input register and the result register; the extra wait covers that with margin.
  task automatic wait_idle();
    do @(negedge clk);
    while (edge_queue.size() != 0 || in_if.valid || pending_decodes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Calm windows: stretches where neither side idles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(199) == 0) calm_left <= $urandom_range(150, 50);
  end

  // ---------------------------------------------------------------------------
  // Driver: one edge per transfer, random gaps between edges. The expectation
  // is computed when the transfer happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_edges
    in_item_t nxt;
    int       send_gap;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.duration <= '0;
      in_if.last     <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        pending_decodes.push_back(decode_edge(in_if.duration, in_if.last));
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (edge_queue.size() > 0) begin
          nxt = edge_queue.pop_front();
          in_if.valid    <= 1'b1;
          in_if.duration <= nxt.duration;
          in_if.last     <= nxt.last;
          send_gap = (calm_left > 0) ? 0 : draw_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin : stall_results
    int stall_left;
    int g;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      g = (calm_left > 0 || $urandom_range(1)) ? 0 : draw_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual bit %0b/%0b",
                 $time, out_if.bit_valid, out_if.bit_value);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("bit_valid",    want.bit_valid,    out_if.bit_valid);
        check_field("bit_value",    want.bit_value,    out_if.bit_value);
        check_field("bit_position", want.bit_position, out_if.bit_position);
        check_field("done_res",     want.done_res,     out_if.done_res);
        check_field("total_bits",   want.total_bits,   out_if.total_bits);
        check_field("decoded_ok",   want.decoded_ok,   out_if.decoded_ok);
        check_field("frame_low",    want.frame_low,    out_if.frame_low);
        check_field("frame_high",   want.frame_high,   out_if.frame_high);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    // Reset defaults: sync 40, one at 8, frame end 30, earliest 6.
    // Big lows before the earliest index, sync at 7, bits 0 1 1 0 with the
    // threshold values, frame end, a low after the end, last on a high.
    int unsigned dir_durs [21];
    int rand_start;

    dir_durs = '{MAX_DUR, MAX_DUR, 1, 39, 2, 40, 3, 40, 1, 7, 1, 8,
                 1, 29, 1, 1, 1, 30, 1, 5, MAX_DUR};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.duration = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    shadow_cfg = '{sync_gap_min: SYNC_GAP_RST, bit1_min: BIT1_MIN_RST,
                   stop_gap_min: STOP_GAP_RST, sync_earliest: SYNC_EARLIEST_RST,
                   min_bits: MIN_BITS_RST};
    restart_capture();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_durs[k]) stage(dir_durs[k]);
    flush_capture();
    stage(10);  // capture of a single high edge: never synced
    flush_capture();
    wait_idle();

    // Lowest thresholds: any low syncs, every data low ends the frame,
    // zero bits already count as decoded
    apply_cfg(1, 1, 1, 0, 0);
    add_capture(3, TAIL_LAST_ON_BIT);
    add_capture(2, TAIL_END_GAP);
    add_noise(12);
    wait_idle();

    // Highest thresholds: no low before index 511, so the hunt never ends
    apply_cfg(MAX_DUR, MAX_DUR, MAX_DUR, 511, BIT_LIMIT);
    add_noise(20);
    wait_idle();

    // Full frame: bit limit reached, high word filled, decoded exactly at 80
    apply_cfg(100, 20, MAX_DUR, 3, BIT_LIMIT);
    add_capture(BIT_LIMIT, TAIL_LAST_ON_BIT);
    wait_idle();

    // Random part: a new register setting every few captures
    rand_start = edges_queued;
    while (edges_queued - rand_start < RANDOM_EDGES) begin
      randomize_cfg();
      repeat ($urandom_range(5, 2))
        if (edges_queued - rand_start < RANDOM_EDGES) add_random_capture();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ookpwm_pkg.sv
hdl/ookpwm_in_if.sv
hdl/ookpwm_out_if.sv
hdl/ookpwm_cfg_regs.sv
hdl/ookpwm_in_stage.sv
hdl/ookpwm_decode.sv
hdl/ook_pwm_pulse_decoder_unit.sv
bench/tb_ook_pwm_pulse_decoder_unit.sv
